### sv/barometric_sensor_compensation_macros.svh
// ----------------------------------------------------------------------------
// Barometric compensation assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication
`define BSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants and types of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsc_pkg;

  // formula constants
  localparam int unsigned PR_OFFSET_FINE = 128000;
  localparam int unsigned PR_BASE        = 1048576;
  localparam int unsigned PR_SCALE       = 3125;
  localparam int unsigned TR_ROUND       = 128;

  // divider geometry: quotient bits and divisor magnitude width
  localparam int unsigned QW    = 64;
  localparam int unsigned DEN_W = 31;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP_CAL     = 2'd0,
    CFG_PRESS_FIRST  = 2'd1,
    CFG_PRESS_SECOND = 2'd2,
    CFG_PRESS_NINTH  = 2'd3
  } cfg_index_t;

  // calibration words as written
  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_first;
    logic [63:0] press_second;
    logic [15:0] press_ninth;
  } cal_t;

  // one divider cell stage
  typedef struct packed {
    logic             v;
    logic [23:0]      temp;
    logic             neg;
    logic             dz;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    work;
  } div_cell_t;

endpackage

### sv/bsc_sample_if.sv
// ----------------------------------------------------------------------------
// bsc_sample_if
// Input stream: one raw temperature and pressure reading pair per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

### sv/bsc_result_if.sv
// ----------------------------------------------------------------------------
// bsc_result_if
// Output stream: compensated temperature and pressure per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsc_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] temperature_centideg;
  logic        [31:0] pressure_q24_8;
  logic               pressure_valid;

  modport source (output valid, temperature_centideg, pressure_q24_8, pressure_valid,
                  input ready);
  modport sink   (input valid, temperature_centideg, pressure_q24_8, pressure_valid,
                  output ready);
endinterface

### sv/bsc_mul64.sv
// ----------------------------------------------------------------------------
// bsc_mul64
// Two-stage 64x64 multiplier returning the low 64 product bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);

  logic [63:0] pp_ll;
  logic [31:0] pp_lh;
  logic [31:0] pp_hl;
  logic [63:0] pp_ll_c;
  logic [31:0] pp_lh_c;
  logic [31:0] pp_hl_c;

  // 32x32 partial products; the high-high term falls off the top
  always_comb begin
    pp_ll_c = 64'(a[31:0]) * 64'(b[31:0]);
    pp_lh_c = a[31:0] * b[63:32];
    pp_hl_c = a[63:32] * b[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= pp_ll_c;
      pp_lh <= pp_lh_c;
      pp_hl <= pp_hl_c;
      y     <= pp_ll + {pp_lh + pp_hl, 32'd0};
    end
  end

endmodule

### sv/bsc_div_cell.sv
// ----------------------------------------------------------------------------
// bsc_div_cell
// One restoring-division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_div_cell
  import bsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  div_cell_t cell_in,
  output div_cell_t cell_out
);

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] den_ext;
  logic [DEN_W:0] diff;
  logic           ge;
  div_cell_t      step;

  // bring down the next dividend bit and try the subtract
  always_comb begin
    shifted = {cell_in.rem, cell_in.work[QW-1]};
    den_ext = {1'b0, cell_in.den};
    diff    = shifted - den_ext;
    ge      = (shifted >= den_ext);
    step    = cell_in;
    step.rem  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    step.work = {cell_in.work[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.v <= 1'b0;
    end else if (en) begin
      cell_out <= step;
    end
  end

endmodule

### sv/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front
// Temperature formula and pressure dividend/divisor, nine register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_front
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        take,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  cal_t        cal,
  output div_cell_t   fout
);

  typedef struct packed {
    logic [23:0] temp;
    logic [20:0] pd;
  } side_t;

  logic        [15:0] t1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
  logic        [15:0] p1;

  assign t1 = cal.temp_cal[15:0];
  assign t2 = cal.temp_cal[31:16];
  assign t3 = cal.temp_cal[47:32];
  assign p1 = cal.press_first[15:0];
  assign p2 = cal.press_first[31:16];
  assign p3 = cal.press_first[47:32];
  assign p4 = cal.press_first[63:48];
  assign p5 = cal.press_second[15:0];
  assign p6 = cal.press_second[31:16];

  logic [7:0] vld;
  side_t      side [8];

  logic        [31:0] r1_ta, r1_dd;
  logic signed [20:0] r2_tv1;
  logic signed [17:0] r2_tb;
  logic signed [21:0] r3_fine;
  logic signed [22:0] r4_u;
  logic signed [45:0] r5_uu;
  logic signed [38:0] r5_up5, r5_up2, r6_up5, r6_up2;
  logic signed [61:0] r6_a, r6_g;
  logic signed [63:0] r7_v2;
  logic signed [54:0] r7_v1p;
  logic        [30:0] r8_fp;
  logic        [63:0] r8_n;

  logic signed [17:0] a_s;
  logic signed [16:0] d_s;
  logic signed [33:0] ta_full, dd_full;
  logic        [20:0] pd_in;
  logic signed [20:0] tv1;
  logic signed [19:0] x_s;
  logic signed [35:0] tb_full;
  logic signed [25:0] t5;
  logic signed [45:0] uu_full;
  logic signed [38:0] up5_full, up2_full;
  logic signed [61:0] a_full, g_full;
  logic signed [63:0] v2;
  logic signed [54:0] v1p;
  logic signed [55:0] base;
  logic signed [16:0] p1_s;
  logic signed [72:0] fp_full;
  logic signed [63:0] nn;
  logic        [63:0] n_prod;
  logic               nb, na;
  logic        [30:0] den_mag;
  logic        [63:0] num_mag;

  always_comb begin
    // stage 1: offsets and the first temperature products
    a_s     = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    d_s     = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    ta_full = a_s * t2;
    dd_full = d_s * d_s;
    pd_in   = 21'(PR_BASE) - {1'b0, raw_pressure};
    // stage 2: scale and third coefficient
    tv1     = r1_ta[31:11];
    x_s     = r1_dd[31:12];
    tb_full = x_s * t3;
    // stage 4: temperature output and offset fine value
    t5      = 26'(r3_fine) * 26'sd5 + 26'(TR_ROUND);
    // stage 5 and 6: pressure polynomial products
    uu_full  = r4_u * r4_u;
    up5_full = r4_u * p5;
    up2_full = r4_u * p2;
    a_full   = r5_uu * p6;
    g_full   = r5_uu * p3;
    // stage 7: sum the two polynomials
    v2  = 64'(r6_a) + (64'(r6_up5) <<< 17) + (64'(p4) <<< 35);
    v1p = 55'(r6_g >>> 8) + (55'(r6_up2) <<< 12);
    // stage 8: divisor product and scaled dividend
    base    = 56'(r7_v1p) + (56'sd1 <<< 47);
    p1_s    = $signed({1'b0, p1});
    fp_full = base * p1_s;
    nn      = $signed(64'(side[6].pd) << 31) - r7_v2;
    n_prod  = nn * 64'(PR_SCALE);
    // stage 9: signs and magnitudes for the divider
    nb      = r8_fp[30];
    na      = r8_n[63];
    den_mag = nb ? (31'd0 - r8_fp) : r8_fp;
    num_mag = na ? (64'd0 - r8_n) : r8_n;
  end

  // stage valid bits and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      fout.v <= 1'b0;
    end else if (en) begin
      vld    <= {vld[6:0], take};
      fout.v <= vld[7];
    end
    if (en) begin
      side[0] <= '{temp: 24'd0, pd: pd_in};
      for (int k = 1; k < 3; k++) begin
        side[k] <= side[k-1];
      end
      side[3] <= '{temp: 24'(t5 >>> 8), pd: side[2].pd};
      for (int k = 4; k < 8; k++) begin
        side[k] <= side[k-1];
      end

      r1_ta   <= ta_full[31:0];
      r1_dd   <= dd_full[31:0];
      r2_tv1  <= tv1;
      r2_tb   <= tb_full[31:14];
      r3_fine <= 22'(r2_tv1) + 22'(r2_tb);
      r4_u    <= 23'(r3_fine) - 23'(PR_OFFSET_FINE);
      r5_uu   <= uu_full;
      r5_up5  <= up5_full;
      r5_up2  <= up2_full;
      r6_a    <= a_full;
      r6_g    <= g_full;
      r6_up5  <= r5_up5;
      r6_up2  <= r5_up2;
      r7_v2   <= v2;
      r7_v1p  <= v1p;
      r8_fp   <= fp_full[63:33];
      r8_n    <= n_prod;

      fout.temp <= side[7].temp;
      fout.neg  <= na ^ nb;
      fout.dz   <= (r8_fp == 31'd0);
      fout.den  <= den_mag;
      fout.rem  <= '0;
      fout.work <= num_mag;
    end
  end

endmodule

### sv/bsc_post.sv
// ----------------------------------------------------------------------------
// bsc_post
// Quotient sign, second-order pressure correction, saturation, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_post
  import bsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  div_cell_t          quo,
  input  cal_t               cal,
  output logic               out_v,
  output logic signed [23:0] out_temp,
  output logic        [31:0] out_press,
  output logic               out_pvalid
);

  typedef struct packed {
    logic [23:0] temp;
    logic        dz;
  } pside_t;

  logic signed [15:0] p7, p8, p9;
  assign p7 = cal.press_second[47:32];
  assign p8 = cal.press_second[63:48];
  assign p9 = cal.press_ninth;

  logic   [4:0] vld;
  pside_t       side [5];

  logic signed [63:0] r1_p, r2_p, r3_p, r4_p;
  logic signed [50:0] r1_s, r2_s;
  logic signed [63:0] r2_x, r2_w, r3_w, r4_w;
  logic signed [63:0] r5_sum;
  logic        [63:0] y;

  logic        [63:0] p_c;
  logic signed [66:0] x_full;
  logic signed [79:0] w_full;
  logic signed [63:0] sum_c;
  logic signed [63:0] res;
  logic        [31:0] sat;

  // third product: (p9 * s) * s
  bsc_mul64 u_mul (
    .clk (clk),
    .en  (en),
    .a   (r2_x),
    .b   (64'(r2_s)),
    .y   (y)
  );

  always_comb begin
    p_c    = quo.neg ? (64'd0 - quo.work) : quo.work;
    x_full = r1_s * p9;
    w_full = r1_p * p8;
    sum_c  = r4_p + ($signed(y) >>> 25) + (r4_w >>> 19);
    res    = (r5_sum >>> 8) + (64'(p7) <<< 4);
    // clamp to the unsigned 32-bit range
    if (res[63]) begin
      sat = 32'd0;
    end else if (res[63:32] != 32'd0) begin
      sat = 32'hFFFF_FFFF;
    end else begin
      sat = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      vld   <= {vld[3:0], quo.v};
      out_v <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{temp: quo.temp, dz: quo.dz};
      for (int k = 1; k < 5; k++) begin
        side[k] <= side[k-1];
      end
      r1_p   <= p_c;
      r1_s   <= p_c[63:13];
      r2_p   <= r1_p;
      r2_s   <= r1_s;
      r2_x   <= x_full[63:0];
      r2_w   <= w_full[63:0];
      r3_p   <= r2_p;
      r3_w   <= r2_w;
      r4_p   <= r3_p;
      r4_w   <= r3_w;
      r5_sum <= sum_c;

      out_temp   <= side[4].temp;
      out_press  <= side[4].dz ? 32'd0 : sat;
      out_pvalid <= ~side[4].dz;
    end
  end

endmodule

### sv/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Pipeline from input transfer to result: 9 front stages, 64 divider cells,
// 6 correction and output stages; the 64-cell divider chain sets depth.
// Throughput: one reading pair per cycle unless the output stalls.
// Whole pipeline stalls only while the output register holds an untaken result.
// Reset (synchronous) clears stage valid bits and calibration registers to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  bsc_sample_if.sink    sample,
  bsc_result_if.source  result
);

  cal_t      cal;
  logic      en;
  logic      out_v;
  div_cell_t link [QW+1];

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_TEMP_CAL:     cal.temp_cal     <= cfg_data[47:0];
        CFG_PRESS_FIRST:  cal.press_first  <= cfg_data;
        CFG_PRESS_SECOND: cal.press_second <= cfg_data;
        CFG_PRESS_NINTH:  cal.press_ninth  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output holds a result not yet taken
  assign en           = ~out_v | result.ready;
  assign sample.ready = en;
  assign result.valid = out_v;

  bsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .take            (sample.valid & en),
    .raw_temperature (sample.raw_temperature),
    .raw_pressure    (sample.raw_pressure),
    .cal             (cal),
    .fout            (link[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < QW; i++) begin : g_div
    bsc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_in  (link[i]),
      .cell_out (link[i+1])
    );
  end

  bsc_post u_post (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .quo        (link[QW]),
    .cal        (cal),
    .out_v      (out_v),
    .out_temp   (result.temperature_centideg),
    .out_press  (result.pressure_q24_8),
    .out_pvalid (result.pressure_valid)
  );

endmodule

### sv/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "barometric_sensor_compensation_macros.svh"

module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_temp,
  input logic [31:0] out_press,
  input logic        out_pvalid
);

  // a waiting result stays and holds its payload
  `BSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `BSC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_temp) && $stable(out_press) && $stable(out_pvalid), "result changed while stalled")

  // input is open whenever the output register is empty
  `BSC_ASSERT_IMPLY(a_ready_free, clk, rst, !out_valid, in_ready, "input blocked with empty output")

  // divisor-zero results carry zero pressure
  `BSC_ASSERT_IMPLY(a_zero_press, clk, rst, out_valid && !out_pvalid, out_press == 32'd0, "invalid pressure not zero")

  // reset empties the pipeline
  `BSC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "result after reset")

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_temp   (result.temperature_centideg),
  .out_press  (result.pressure_q24_8),
  .out_pvalid (result.pressure_valid)
);

### tb/bsc_compensation_checker.sv
// ----------------------------------------------------------------------------
// Compensation result checker
// Watches the reading and result streams, predicts temperature and pressure
// for every accepted reading pair and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_compensation_checker
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  bsc_sample_if       sample,
  bsc_result_if       result,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic signed [23:0] temp;
    logic [31:0]        press;
    logic               pvalid;
  } comp_result_t;

  logic [47:0] cal_t_word;
  logic [63:0] cal_p_first;
  logic [63:0] cal_p_second;
  logic [15:0] cal_p_ninth;

  comp_result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // arithmetic right shift of a 64-bit word
  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

  // signed divide, truncating, wrapping at 64 bits
  function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q  = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // fine temperature, temperature and pressure for one reading pair
  function automatic comp_result_t compensate(input logic [19:0] adc_t,
                                              input logic [19:0] adc_p);
    comp_result_t r;
    logic [31:0] t1, t2, t3, a, tv1, d, dd, tv2, fine, tmp;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] f64, v1, v2, p, w1, w2;
    t1 = {16'd0, cal_t_word[15:0]};
    t2 = sx16(cal_t_word[31:16]);
    t3 = sx16(cal_t_word[47:32]);
    p1 = {48'd0, cal_p_first[15:0]};
    p2 = sx16(cal_p_first[31:16]);
    p3 = sx16(cal_p_first[47:32]);
    p4 = sx16(cal_p_first[63:48]);
    p5 = sx16(cal_p_second[15:0]);
    p6 = sx16(cal_p_second[31:16]);
    p7 = sx16(cal_p_second[47:32]);
    p8 = sx16(cal_p_second[63:48]);
    p9 = sx16(cal_p_ninth);
    // temperature, 32-bit wrap
    a    = {12'd0, adc_t} >> 3;
    a    = a - (t1 << 1);
    tv1  = $signed(a * t2) >>> 11;
    d    = ({12'd0, adc_t} >> 4) - t1;
    dd   = $signed(d * d) >>> 12;
    tv2  = $signed(dd * t3) >>> 14;
    fine = tv1 + tv2;
    tmp  = $signed(fine * 32'd5 + TR_ROUND) >>> 8;
    r.temp = tmp[23:0];
    // pressure, 64-bit wrap
    f64 = {{32{fine[31]}}, fine};
    v1  = f64 - 64'(PR_OFFSET_FINE);
    v2  = v1 * v1 * p6;
    v2  = v2 + ((v1 * p5) << 17);
    v2  = v2 + (p4 << 35);
    v1  = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1  = asr64(((64'd1 << 47) + v1) * p1, 33);
    r.press  = '0;
    r.pvalid = 1'b0;
    if (v1 != 0) begin
      r.pvalid = 1'b1;
      p  = 64'(PR_BASE) - {44'd0, adc_p};
      p  = div_trunc(((p << 31) - v2) * 64'(PR_SCALE), v1);
      w1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
      w2 = asr64(p8 * p, 19);
      p  = asr64(p + w1 + w2, 8) + (p7 << 4);
      if (p[63]) r.press = '0;
      else if (p > 64'hFFFF_FFFF) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
    end
    return r;
  endfunction

  // calibration shadow, predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    comp_result_t e;
    if (rst) begin
      cal_t_word   <= '0;
      cal_p_first  <= '0;
      cal_p_second <= '0;
      cal_p_ninth  <= '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TEMP_CAL:     cal_t_word   <= cfg_data[47:0];
          CFG_PRESS_FIRST:  cal_p_first  <= cfg_data;
          CFG_PRESS_SECOND: cal_p_second <= cfg_data;
          CFG_PRESS_NINTH:  cal_p_ninth  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        expected_results.push_back(compensate(sample.raw_temperature, sample.raw_pressure));
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (result.temperature_centideg !== e.temp) begin
            $error("temperature_centideg: expected %0d, got %0d", e.temp,
                   result.temperature_centideg);
            fail_count++;
          end
          if (result.pressure_q24_8 !== e.press) begin
            $error("pressure_q24_8: expected %0h, got %0h", e.press, result.pressure_q24_8);
            fail_count++;
          end
          if (result.pressure_valid !== e.pvalid) begin
            $error("pressure_valid: expected %0b, got %0b", e.pvalid, result.pressure_valid);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### tb/barometric_sensor_compensation_tb.sv
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives calibration settings and reading pairs with random gaps and output
// stalls, including one long output hold-off; the checker does the compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barometric_sensor_compensation_tb;
  import bsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_TEMP_CAL;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending_count;
  bit          calm = 1'b0;
  int          holdoff = 0;

  bsc_sample_if sample ();
  bsc_result_if result ();

  initial begin
    sample.valid = 1'b0;
    sample.raw_temperature = '0;
    sample.raw_pressure = '0;
    result.ready = 1'b0;
  end

  barometric_sensor_compensation i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(sample), .result(result)
  );

  bsc_compensation_checker i_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(sample), .result(result),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, long hold-off when requested
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (holdoff > 0) begin
      result.ready <= 1'b0;
      holdoff <= holdoff - 1;
    end else result.ready <= calm || ($urandom_range(99) >= 30);
  end

  // one register write, then the write strobe is lowered before the task returns
  task automatic write_cal(input cfg_index_t idx, input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // one reading pair, with optional idle cycles in front
  task automatic send_reading(input logic [19:0] t, input logic [19:0] p);
    while (!calm && $urandom_range(99) < 30) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.raw_temperature <= t;
    sample.raw_pressure <= p;
    do @(posedge clk); while (!sample.ready);
  endtask

  // stop sending and wait until every result is back
  task automatic drain;
    sample.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_cal(input bit extreme);
    if (extreme) begin
      write_cal(CFG_TEMP_CAL, $urandom_range(1) ? '1 : '0);
      write_cal(CFG_PRESS_FIRST, $urandom_range(1) ? 64'h8000_8000_8000_FFFF : '1);
      write_cal(CFG_PRESS_SECOND, $urandom_range(1) ? 64'h7FFF_7FFF_7FFF_7FFF
                                                    : 64'h8000_8000_8000_8000);
      write_cal(CFG_PRESS_NINTH, $urandom_range(1) ? 64'h7FFF : 64'h8000);
    end else begin
      // typical sensor trimming with random spread
      write_cal(CFG_TEMP_CAL, {16'($urandom_range(0, 100) - 50), 16'(26435 + $urandom_range(400)),
                               16'(27504 + $urandom_range(2000))});
      write_cal(CFG_PRESS_FIRST, {16'(2855 + $urandom_range(200)), 16'($urandom_range(4095)),
                                  16'(-10685 - $urandom_range(200)),
                                  16'(36477 + $urandom_range(2000))});
      write_cal(CFG_PRESS_SECOND, {16'(-12000 - $urandom_range(3000)), 16'(15500),
                                   16'(-7), 16'(140 + $urandom_range(100))});
      write_cal(CFG_PRESS_NINTH, 64'(6000 + $urandom_range(1000)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset calibration: divisor zero
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    drain();
    random_cal(1'b0);
    // directed: field extremes and single bits
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h80000, 20'h7FFFF);
    send_reading(20'h7FFFF, 20'h80000);
    send_reading(20'd519888, 20'd415148);
    for (int b = 0; b < 20; b += 4) send_reading(20'(1 << b), 20'(1 << (19 - b)));
    drain();
    // extreme calibrations: wrap, saturation, most negative over minus one
    for (int k = 0; k < 4; k++) begin
      random_cal(1'b1);
      for (int i = 0; i < 4; i++) send_reading(20'($urandom), 20'($urandom));
      drain();
    end
    write_cal(CFG_PRESS_FIRST, '0);
    send_reading(20'd500000, 20'd400000);
    drain();
    // long output hold-off with a calm sender: pipeline fills and stalls input
    calm = 1'b1;
    random_cal(1'b0);
    holdoff <= 300;
    for (int i = 0; i < 120; i++) send_reading(20'($urandom), 20'($urandom));
    calm = 1'b0;
    drain();
    // random phases with realistic and occasionally random calibration
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 4 == 3) begin
        write_cal(CFG_TEMP_CAL, {$urandom, $urandom});
        write_cal(CFG_PRESS_FIRST, {$urandom, $urandom});
        write_cal(CFG_PRESS_SECOND, {$urandom, $urandom});
        write_cal(CFG_PRESS_NINTH, {$urandom, $urandom});
      end else random_cal(1'b0);
      calm = (ph == 2);
      for (int i = 0; i < 30; i++)
        if ($urandom_range(3) == 0) send_reading(20'($urandom), 20'($urandom));
        else send_reading(20'(400000 + $urandom_range(250000)),
                          20'(250000 + $urandom_range(250000)));
      calm = 1'b0;
      drain();
    end
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/bsc_pkg.sv
sv/bsc_sample_if.sv
sv/bsc_result_if.sv
sv/bsc_mul64.sv
sv/bsc_div_cell.sv
sv/bsc_front.sv
sv/bsc_post.sv
sv/barometric_sensor_compensation.sv
sv/bsc_checker.sv
tb/bsc_compensation_checker.sv
tb/barometric_sensor_compensation_tb.sv
